FILE: rtl/pcc_pkg.sv
// Shared types, widths and constants of the polar/Cartesian CORDIC converter.
package pcc_pkg;

	localparam int MAX_ITER = 24;
	localparam int XY_W = 48;
	localparam int Z_W = 35;
	localparam int KINV_W = 30;
	localparam int PROD_W = 16 + KINV_W + 1;
	localparam int MAG_W = 31;
	localparam int RP_W = 62;
	localparam int ANG_SHIFT = 17;
	localparam int VEC_FRAC = 14;
	localparam int XY_FRAC = 30;
	localparam int R_SHIFT = 44;
	localparam int RND_XY = 1 << 29;
	localparam int RND_Z = 1 << 16;
	localparam int ANGLE_LIMIT = 25736;
	localparam int RADIUS_MAX = 65535;

	localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;
	localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic [RP_W-1:0] RND_R = RP_W'(1) << (R_SHIFT - 1);

	localparam logic [29:0] ATAN_Q30 [MAX_ITER] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687, 30'd33543516, 30'd16775851, 30'd8388437,
		30'd4194283, 30'd2097149, 30'd1048576, 30'd524288,
		30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048,
		30'd1024, 30'd512, 30'd256, 30'd128
	};

	localparam logic OP_TO_CART = 1'b0;
	localparam logic OP_TO_POLAR = 1'b1;

	typedef struct packed {
		logic opcode;
		logic signed [15:0] x_in;
		logic signed [15:0] y_in;
		logic signed [15:0] angle_in;
		logic [14:0] radius_in;
	} pcc_cmd_t;

	typedef struct packed {
		logic signed [15:0] x_out;
		logic signed [15:0] y_out;
		logic signed [15:0] angle_out;
		logic [15:0] radius_out;
		logic radius_zero;
	} pcc_res_t;

	typedef struct packed {
		logic zero;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		pcc_cmd_t cmd;
	} pcc_work_t;

endpackage

FILE: rtl/pcc_if.sv
// Valid/ready stream interfaces for the converter's command and result channels.
interface pcc_cmd_if;
	import pcc_pkg::*;
	logic valid;
	logic ready;
	pcc_cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pcc_res_if;
	import pcc_pkg::*;
	logic valid;
	logic ready;
	pcc_res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/pcc_pre.sv
// Input stage: quadrant folding, gain preload and start vector of the CORDIC pipeline.
module pcc_pre (
	input logic clk,
	input logic arst_n,
	pcc_cmd_if.sink cmd,
	output logic dn_valid,
	input logic dn_ready,
	output pcc_pkg::pcc_work_t dn_data
);
	import pcc_pkg::*;

	logic signed [Z_W-1:0] za;
	logic fold_hi;
	logic fold_lo;
	logic signed [KINV_W:0] gain;
	logic signed [PROD_W-1:0] prod;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic valid_s1;
	pcc_work_t nxt;
	pcc_work_t work_s1;

	assign cmd.ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_data = work_s1;

	always_comb begin
		za = Z_W'(cmd.data.angle_in) <<< ANG_SHIFT;
		fold_hi = za > HALF_PI_Q30;
		fold_lo = za < -HALF_PI_Q30;
		gain = (fold_hi || fold_lo) ? -$signed({1'b0, KINV_Q30}) : $signed({1'b0, KINV_Q30});
		prod = $signed({1'b0, cmd.data.radius_in}) * gain;
		xs = XY_W'(cmd.data.x_in) <<< VEC_FRAC;
		ys = XY_W'(cmd.data.y_in) <<< VEC_FRAC;
		nxt.cmd = cmd.data;
		nxt.zero = 1'b0;
		if (cmd.data.opcode == OP_TO_CART) begin
			nxt.x = XY_W'(prod);
			nxt.y = '0;
			if (fold_hi) begin
				nxt.z = za - PI_Q30;
			end else if (fold_lo) begin
				nxt.z = za + PI_Q30;
			end else begin
				nxt.z = za;
			end
		end else begin
			nxt.zero = (cmd.data.x_in == '0) && (cmd.data.y_in == '0);
			if (cmd.data.x_in[15]) begin
				nxt.x = -xs;
				nxt.y = -ys;
				nxt.z = cmd.data.y_in[15] ? -PI_Q30 : PI_Q30;
			end else begin
				nxt.x = xs;
				nxt.y = ys;
				nxt.z = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			work_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/pcc_stage.sv
// One CORDIC micro-rotation stage, shared by rotation and vectoring mode.
module pcc_stage #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input pcc_pkg::pcc_work_t up_data,
	output logic dn_valid,
	input logic dn_ready,
	output pcc_pkg::pcc_work_t dn_data
);
	import pcc_pkg::*;

	logic ccw;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0] da;
	logic valid_s1;
	pcc_work_t nxt;
	pcc_work_t work_s1;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_data = work_s1;

	always_comb begin
		nxt = up_data;
		dx = up_data.y >>> IDX;
		dy = up_data.x >>> IDX;
		da = Z_W'(ATAN_Q30[IDX]);
		// Rotation drives z toward zero, vectoring drives y toward zero.
		ccw = (up_data.cmd.opcode == OP_TO_POLAR) ? up_data.y[XY_W-1] : !up_data.z[Z_W-1];
		if (ccw) begin
			nxt.x = up_data.x - dx;
			nxt.y = up_data.y + dy;
			nxt.z = up_data.z - da;
		end else begin
			nxt.x = up_data.x + dx;
			nxt.y = up_data.y - dy;
			nxt.z = up_data.z + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			work_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/pcc_post.sv
// Output stages: rounding, saturation, gain correction of the length and result register.
module pcc_post #(
	parameter int DATA_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input pcc_pkg::pcc_work_t up_data,
	pcc_res_if.source res
);
	import pcc_pkg::*;

	localparam int OUT_BITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
	localparam int SAT_MAX = (1 << (OUT_BITS - 1)) - 1;
	localparam int SAT_MIN = -SAT_MAX - 1;

	logic signed [XY_W-1:0] xsum;
	logic signed [XY_W-1:0] ysum;
	logic signed [XY_W-1:0] xr;
	logic signed [XY_W-1:0] yr;
	logic signed [Z_W-1:0] zsum;
	logic signed [Z_W-1:0] zr;
	logic signed [15:0] xsat;
	logic signed [15:0] ysat;
	logic signed [15:0] asat;
	logic [MAG_W-1:0] mag;
	logic [RP_W-1:0] rsum;
	logic [RP_W-1:0] rr;
	logic [15:0] rsat;
	logic mid_ready;
	logic valid_s1;
	logic op_s1;
	logic zero_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic signed [15:0] angle_s1;
	logic [14:0] radius_s1;
	logic [RP_W-1:0] rprod_s1;
	logic valid_s2;
	pcc_res_t res_s2;
	pcc_res_t nxt;

	assign up_ready = !valid_s1 || mid_ready;
	assign mid_ready = !valid_s2 || res.ready;
	assign res.valid = valid_s2;
	assign res.data = res_s2;

	always_comb begin
		xsum = up_data.x + XY_W'(RND_XY);
		ysum = up_data.y + XY_W'(RND_XY);
		xr = xsum >>> XY_FRAC;
		yr = ysum >>> XY_FRAC;
		if (xr > SAT_MAX) begin
			xsat = 16'(SAT_MAX);
		end else if (xr < SAT_MIN) begin
			xsat = 16'(SAT_MIN);
		end else begin
			xsat = 16'(xr);
		end
		if (yr > SAT_MAX) begin
			ysat = 16'(SAT_MAX);
		end else if (yr < SAT_MIN) begin
			ysat = 16'(SAT_MIN);
		end else begin
			ysat = 16'(yr);
		end
		zsum = up_data.z + Z_W'(RND_Z);
		zr = zsum >>> ANG_SHIFT;
		if (zr > ANGLE_LIMIT) begin
			asat = 16'(ANGLE_LIMIT);
		end else if (zr < -ANGLE_LIMIT) begin
			asat = 16'(-ANGLE_LIMIT);
		end else begin
			asat = 16'(zr);
		end
		mag = up_data.x[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			op_s1 <= up_data.cmd.opcode;
			zero_s1 <= up_data.zero;
			radius_s1 <= up_data.cmd.radius_in;
			rprod_s1 <= mag * KINV_Q30;
			if (up_data.cmd.opcode == OP_TO_CART) begin
				x_s1 <= xsat;
				y_s1 <= ysat;
				angle_s1 <= up_data.cmd.angle_in;
			end else begin
				x_s1 <= up_data.cmd.x_in;
				y_s1 <= up_data.cmd.y_in;
				angle_s1 <= up_data.zero ? '0 : asat;
			end
		end
	end

	always_comb begin
		rsum = rprod_s1 + RND_R;
		rr = rsum >> R_SHIFT;
		rsat = (rr > RADIUS_MAX) ? 16'(RADIUS_MAX) : 16'(rr);
		nxt.x_out = x_s1;
		nxt.y_out = y_s1;
		nxt.angle_out = angle_s1;
		if (op_s1 == OP_TO_CART) begin
			nxt.radius_out = {1'b0, radius_s1};
			nxt.radius_zero = 1'b0;
		end else begin
			nxt.radius_out = zero_s1 ? '0 : rsat;
			nxt.radius_zero = zero_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (mid_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_ready && valid_s1) begin
			res_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/polar_cartesian_converter_core.sv
// Top level of the pipelined CORDIC polar/Cartesian converter.
// Commands arrive on the cmd channel and results leave on the res channel, both
// valid/ready streams; a beat moves when valid and ready are high at a clock edge.
// Opcode 0 rotates (radius_in, 0) by angle_in and returns x_out and y_out, saturated,
// with angle_in and radius_in echoed. Opcode 1 vectors (x_in, y_in) and returns
// radius_out and angle_out with x_in and y_in echoed; a zero vector gives a zero
// length and angle and raises radius_zero.
// The pipeline has one input stage, one stage per CORDIC iteration and two output
// stages; res.valid rises once the command beat has passed through all of them, and
// the result beat moves when the receiver does not stall. One command beat is taken
// every cycle unless a stalled receiver has filled the pipeline.
// Each stage holds its data while the stage after it is full and stalled, and an
// empty stage takes a new beat even while later stages wait, so a stalled receiver
// fills the pipeline before cmd.ready falls. Nothing is lost or repeated on a stall.
// Reset clears every stage valid bit; the data registers are not reset.
// DATA_WIDTH below 16 narrows the saturation range of x_out and y_out.
module polar_cartesian_converter_core #(
	parameter int ITERATIONS = 16,
	parameter int DATA_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	pcc_cmd_if.sink cmd,
	pcc_res_if.source res
);
	import pcc_pkg::*;

	localparam int ITER_N = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;

	logic st_valid [ITER_N+1];
	logic st_ready [ITER_N+1];
	pcc_work_t st_data [ITER_N+1];

	pcc_pre u_pre (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.dn_valid(st_valid[0]),
		.dn_ready(st_ready[0]),
		.dn_data(st_data[0])
	);

	for (genvar k = 0; k < ITER_N; k++) begin : g_iter
		pcc_stage #(
			.IDX(k)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(st_valid[k]),
			.up_ready(st_ready[k]),
			.up_data(st_data[k]),
			.dn_valid(st_valid[k+1]),
			.dn_ready(st_ready[k+1]),
			.dn_data(st_data[k+1])
		);
	end

	pcc_post #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(st_valid[ITER_N]),
		.up_ready(st_ready[ITER_N]),
		.up_data(st_data[ITER_N]),
		.res(res)
	);

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.radius_zero |-> res.data.angle_out == '0 &&
			res.data.radius_out == '0 && res.data.x_out == '0 && res.data.y_out == '0)
		else $error("Zero-length result carries a nonzero field.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res.ready || !res.valid) |-> cmd.ready)
		else $error("Command channel stalled while the result stage can move.");
`endif

endmodule
